/* rtl/sic_pkg.sv */
// sic_pkg: shared types and constants for the sic cpu core
// no dependencies
package sic_pkg;

    localparam int MemDepth = 32768;
    localparam int MemAw    = $clog2(MemDepth);

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SETPC = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_PCOOR = 2'd1;
    localparam logic [1:0] ST_BADOP = 2'd2;
    localparam logic [1:0] ST_DIV0  = 2'd3;

    localparam logic [2:0] CC_EQ = 3'b001;
    localparam logic [2:0] CC_GT = 3'b010;
    localparam logic [2:0] CC_LT = 3'b100;

    localparam logic [7:0] OP_LDA  = 8'h00;
    localparam logic [7:0] OP_LDX  = 8'h04;
    localparam logic [7:0] OP_LDL  = 8'h08;
    localparam logic [7:0] OP_STA  = 8'h0C;
    localparam logic [7:0] OP_STX  = 8'h10;
    localparam logic [7:0] OP_STL  = 8'h14;
    localparam logic [7:0] OP_ADD  = 8'h18;
    localparam logic [7:0] OP_SUB  = 8'h1C;
    localparam logic [7:0] OP_MUL  = 8'h20;
    localparam logic [7:0] OP_DIV  = 8'h24;
    localparam logic [7:0] OP_COMP = 8'h28;
    localparam logic [7:0] OP_TIX  = 8'h2C;
    localparam logic [7:0] OP_JEQ  = 8'h30;
    localparam logic [7:0] OP_JGT  = 8'h34;
    localparam logic [7:0] OP_JLT  = 8'h38;
    localparam logic [7:0] OP_J    = 8'h3C;
    localparam logic [7:0] OP_AND  = 8'h40;
    localparam logic [7:0] OP_OR   = 8'h44;
    localparam logic [7:0] OP_JSUB = 8'h48;
    localparam logic [7:0] OP_RSUB = 8'h4C;
    localparam logic [7:0] OP_LDCH = 8'h50;
    localparam logic [7:0] OP_STCH = 8'h54;
    localparam logic [7:0] OP_RD   = 8'hD8;
    localparam logic [7:0] OP_WD   = 8'hDC;
    localparam logic [7:0] OP_TD   = 8'hE0;
    localparam logic [7:0] OP_STSW = 8'hE8;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [14:0] address;
        logic [7:0]  byte_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pc_now;
        logic [23:0] acc_now;
        logic        dev_write;
        logic [7:0]  dev_id;
        logic [7:0]  dev_byte;
    } t_out_item;

    // byte address taken to memory reach
    function automatic logic [MemAw-1:0] mem_slot(input logic [14:0] a);
        logic [15:0] t;
        t = {1'b0, a} % 16'(MemDepth);
        return t[MemAw-1:0];
    endfunction

endpackage

/* rtl/sic_alu.sv */
// sic_alu: shared 24-bit arithmetic unit, combinational add/sub/mul and
// a bit-serial restoring divider; uses sic_pkg
module sic_alu
    import sic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start_div,
    input  logic [23:0] i_a,
    input  logic [23:0] i_b,
    output logic [23:0] o_sum,
    output logic [23:0] o_diff,
    output logic [23:0] o_prod,
    output logic        o_div_done,
    output logic [23:0] o_quot
);
    logic [23:0] r_q;
    logic [23:0] r_rem;
    logic [23:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [24:0] rem_sh;
    logic [24:0] rem_sub;
    logic [47:0] prod_full;

    assign o_sum  = i_a + i_b;
    assign o_diff = i_a - i_b;
    assign prod_full = i_a * i_b;
    assign o_prod = prod_full[23:0];
    assign o_quot = r_q;

    assign rem_sh  = {r_rem, r_q[23]};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_cnt      <= '0;
            o_div_done <= 1'b0;
        end else begin
            o_div_done <= 1'b0;
            if (i_start_div) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_q    <= i_a;
                r_rem  <= '0;
                r_div  <= i_b;
            end else if (r_busy) begin
                // one quotient bit per cycle
                if (!rem_sub[24]) begin
                    r_rem <= rem_sub[23:0];
                    r_q   <= {r_q[22:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[23:0];
                    r_q   <= {r_q[22:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    r_busy     <= 1'b0;
                    o_div_done <= 1'b1;
                end
            end
        end
    end
endmodule

/* rtl/sic_cpu_core_top.sv */
// sic_cpu_core_top: sic standard machine core with a 32K-byte memory
// uses sic_pkg and sic_alu
//
// After reset the core runs a clearing pass over the memory, one byte per
// cycle, and takes no item until it ends. A memory write or set-pc item goes
// from idle through the finish and output states back to idle; an execute
// item moves one memory byte per cycle through the memory's read port or
// write port (three instruction bytes read, up to three operand bytes read,
// up to three store bytes written), a halted core answers an execute item
// without a fetch, and a divide waits in the bit-serial divider. One item is
// worked at a time; the result waits in an output register.
module sic_cpu_core_top
    import sic_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_OPND, S_EXEC, S_DIV,
        S_STORE, S_FINISH, S_OUT
    } t_state;

    logic [7:0]       r_mem [MemDepth];
    logic [7:0]       r_rdata;
    t_state           r_state;
    logic [MemAw:0]   r_clr;
    t_in_item         r_item;
    logic [23:0]      r_a, r_x, r_l;
    logic [2:0]       r_cc;
    logic [15:0]      r_pc;
    logic             r_halted;
    logic [1:0]       r_hcode;
    logic [7:0]       r_op;
    logic [15:0]      r_field;
    logic [23:0]      r_word;
    logic [2:0]       r_step;
    logic [23:0]      r_stv;
    logic [14:0]      r_ea;
    logic [16:0]      r_next;
    logic             r_dev;
    t_out_item        r_out;

    logic             mem_we;
    logic [MemAw-1:0] mem_wa;
    logic [7:0]       mem_wd;
    logic [MemAw-1:0] mem_ra;
    logic [14:0]      ea_calc;
    logic [23:0]      x_sum;
    logic [23:0]      alu_b;
    logic [23:0]      alu_sum, alu_diff, alu_prod, alu_quot;
    logic             div_start, div_done;
    logic             opnd_word, opnd_byte, op_valid, is_store;
    logic             fin_commit, fin_oor;
    logic [1:0]       fin_status;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

    assign alu_b = (r_state == S_DIV) ? r_word : r_word;
    assign div_start = (r_state == S_EXEC) && (r_op == OP_DIV) && (r_word != 24'd0);

    sic_alu u_alu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start_div(div_start),
        .i_a        (r_a),
        .i_b        (alu_b),
        .o_sum      (alu_sum),
        .o_diff     (alu_diff),
        .o_prod     (alu_prod),
        .o_div_done (div_done),
        .o_quot     (alu_quot)
    );

    assign x_sum   = r_x + {9'd0, r_field[14:0]};
    assign ea_calc = r_field[15] ? x_sum[14:0] : r_field[14:0];

    always_comb begin
        opnd_word = 1'b0;
        opnd_byte = 1'b0;
        op_valid  = 1'b1;
        is_store  = 1'b0;
        unique case (r_op)
            OP_LDA, OP_LDX, OP_LDL, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_COMP,
            OP_AND, OP_OR: opnd_word = 1'b1;
            OP_LDCH: opnd_byte = 1'b1;
            OP_STA, OP_STX, OP_STL, OP_STCH: is_store = 1'b1;
            OP_TIX, OP_JEQ, OP_JGT, OP_JLT, OP_J, OP_JSUB, OP_RSUB, OP_RD,
            OP_WD, OP_TD, OP_STSW: ;
            default: op_valid = 1'b0;
        endcase
    end

    // memory read address follows the step count of the current phase
    always_comb begin
        mem_ra = mem_slot(r_pc[14:0] + 15'(r_step));
        if (r_state == S_OPND) mem_ra = mem_slot(r_ea + 15'(r_step));
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = mem_slot(r_ea + 15'(r_step));
        mem_wd = r_stv[23:16];
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr[MemAw-1:0];
            mem_wd = 8'd0;
        end else if (r_state == S_IDLE && i_valid && i_data.cmd == CMD_WRITE) begin
            mem_we = 1'b1;
            mem_wa = mem_slot(i_data.address);
            mem_wd = i_data.byte_in;
        end else if (r_state == S_STORE) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    // an execute item that was not halted on entry and did not halt inside
    assign fin_commit = (r_item.cmd == CMD_EXEC) && !r_halted;
    assign fin_oor    = fin_commit && (r_next[15:0] >= 16'(MemDepth));
    assign fin_status = r_halted ? r_hcode : (fin_oor ? ST_PCOOR : ST_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_a      <= '0;
            r_x      <= '0;
            r_l      <= '0;
            r_cc     <= '0;
            r_pc     <= '0;
            r_halted <= 1'b0;
            r_hcode  <= ST_RUN;
            r_step   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (MemAw+1)'(MemDepth - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    r_dev  <= 1'b0;
                    r_step <= '0;
                    if (i_valid) begin
                        r_item <= i_data;
                        if (i_data.cmd == CMD_SETPC) begin
                            r_pc     <= {1'b0, i_data.address};
                            r_halted <= 1'b0;
                            r_hcode  <= ST_RUN;
                            r_state  <= S_FINISH;
                        end else if (i_data.cmd == CMD_EXEC && !r_halted) begin
                            if (r_pc >= 16'(MemDepth)) begin
                                r_halted <= 1'b1;
                                r_hcode  <= ST_PCOOR;
                                r_state  <= S_FINISH;
                            end else begin
                                r_state <= S_FETCH;
                            end
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FETCH: begin
                    // read data is registered and arrives in the cycle after its address
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd1) r_op <= r_rdata & 8'hFC;
                    if (r_step == 3'd2) r_field[15:8] <= r_rdata;
                    if (r_step == 3'd3) begin
                        r_field[7:0] <= r_rdata;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_ea   <= ea_calc;
                    r_next <= 17'(r_pc) + 17'd3;
                    r_step <= '0;
                    r_word <= '0;
                    if (!op_valid) begin
                        r_halted <= 1'b1;
                        r_hcode  <= ST_BADOP;
                        r_state  <= S_FINISH;
                    end else if (opnd_word || opnd_byte) begin
                        r_state <= S_OPND;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_OPND: begin
                    r_step <= r_step + 3'd1;
                    if (r_step != 3'd0) r_word <= {r_word[15:0], r_rdata};
                    if ((opnd_byte && r_step == 3'd1) || r_step == 3'd3)
                        r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_step <= '0;
                    if (is_store)       r_state <= S_STORE;
                    else if (div_start) r_state <= S_DIV;
                    else                r_state <= S_FINISH;
                    case (r_op)
                        OP_LDA:  r_a <= r_word;
                        OP_LDX:  r_x <= r_word;
                        OP_LDL:  r_l <= r_word;
                        OP_STA:  r_stv <= r_a;
                        OP_STX:  r_stv <= r_x;
                        OP_STL:  r_stv <= r_l;
                        OP_STCH: r_stv <= r_a;
                        OP_ADD:  r_a <= alu_sum;
                        OP_SUB:  r_a <= alu_diff;
                        OP_MUL:  r_a <= alu_prod;
                        OP_DIV: begin
                            if (r_word == 24'd0) begin
                                r_halted <= 1'b1;
                                r_hcode  <= ST_DIV0;
                            end
                        end
                        OP_COMP: begin
                            if (r_a > r_word)      r_cc <= CC_GT;
                            else if (r_a < r_word) r_cc <= CC_LT;
                            else                   r_cc <= CC_EQ;
                        end
                        OP_JEQ: if (r_cc[0]) r_next <= {2'b0, r_ea};
                        OP_JGT: if (r_cc[1]) r_next <= {2'b0, r_ea};
                        OP_JLT: if (r_cc[2]) r_next <= {2'b0, r_ea};
                        OP_J:    r_next <= {2'b0, r_ea};
                        OP_AND:  r_a <= r_a & r_word;
                        OP_OR:   r_a <= r_a | r_word;
                        OP_JSUB: begin
                            r_l    <= {8'd0, r_next[15:0]};
                            r_next <= {2'b0, r_ea};
                        end
                        OP_RSUB: r_next <= {1'b0, r_l[15:0]};
                        OP_LDCH: r_a <= {r_word[7:0], r_a[15:0]};
                        OP_WD:   r_dev <= 1'b1;
                        OP_TD:   r_cc <= r_cc | CC_EQ;
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        r_a     <= alu_quot;
                        r_state <= S_FINISH;
                    end
                end
                S_STORE: begin
                    r_step <= r_step + 3'd1;
                    r_stv  <= {r_stv[15:0], 8'd0};
                    if (r_op == OP_STCH || r_step == 3'd2) r_state <= S_FINISH;
                end
                S_FINISH: begin
                    // commit pc only for an instruction that ran to the end
                    if (fin_commit) begin
                        r_pc <= r_next[15:0];
                        if (fin_oor) begin
                            r_halted <= 1'b1;
                            r_hcode  <= ST_PCOOR;
                        end
                    end
                    r_out.status    <= fin_status;
                    r_out.pc_now    <= fin_commit ? r_next[15:0] : r_pc;
                    r_out.acc_now   <= r_a;
                    r_out.dev_write <= r_dev;
                    r_out.dev_id    <= r_dev ? r_ea[7:0] : 8'd0;
                    r_out.dev_byte  <= r_dev ? r_a[23:16] : 8'd0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* dv/sic_cpu_core_top_tb.sv */
// sic_cpu_core_top_tb: self-checking testbench for the sic cpu core
// loads small random programs and data, runs them and checks each result item
// against a predictor of the core; depends on sic_pkg and sic_cpu_core_top
module sic_cpu_core_top_tb
    import sic_pkg::*;
();

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int IdleLimit = 100000;
    localparam int NumItems = 1000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    sic_cpu_core_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    // predictor copy of the core state
    logic [7:0]  mem_img [MemDepth];
    logic [23:0] acc_r, idx_r, lnk_r;
    logic [2:0]  cc_r;
    logic [15:0] pc_r;
    logic        halted_r;
    logic [1:0]  halt_code_r;

    t_in_item  pending_q[$];
    t_out_item expected_q[$];
    int        n_fail = 0;
    int        n_accepted = 0;

    logic [7:0] op_list [26] = '{OP_LDA, OP_LDX, OP_LDL, OP_STA, OP_STX, OP_STL, OP_ADD,
        OP_SUB, OP_MUL, OP_DIV, OP_COMP, OP_TIX, OP_JEQ, OP_JGT, OP_JLT, OP_J, OP_AND,
        OP_OR, OP_JSUB, OP_RSUB, OP_LDCH, OP_STCH, OP_RD, OP_WD, OP_TD, OP_STSW};

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int slot(int a);
        return (a & 32'h7FFF) % MemDepth;
    endfunction

    function automatic logic [7:0] rd_byte(int a);
        return mem_img[slot(a)];
    endfunction

    function automatic logic [23:0] rd_word(int a);
        return {rd_byte(a), rd_byte(a + 1), rd_byte(a + 2)};
    endfunction

    function automatic void wr_word(int a, logic [23:0] v);
        mem_img[slot(a)] = v[23:16];
        mem_img[slot(a + 1)] = v[15:8];
        mem_img[slot(a + 2)] = v[7:0];
    endfunction

    function automatic void halt_with(logic [1:0] code);
        halted_r = 1;
        halt_code_r = code;
    endfunction

    function automatic void exec_instr(ref t_out_item r);
        logic [7:0]  op;
        logic [15:0] field;
        logic [14:0] ea;
        logic [15:0] next_pc;
        logic [23:0] w;
        logic [47:0] prod;
        if (pc_r >= MemDepth) begin
            halt_with(ST_PCOOR);
            return;
        end
        op = rd_byte(pc_r) & 8'hFC;
        field = {rd_byte(pc_r + 1), rd_byte(pc_r + 2)};
        ea = field[14:0];
        if (field[15]) ea = ea + idx_r[14:0];
        next_pc = pc_r + 16'd3;
        w = rd_word(ea);
        case (op)
            OP_LDA:  acc_r = w;
            OP_LDX:  idx_r = w;
            OP_LDL:  lnk_r = w;
            OP_STA:  wr_word(ea, acc_r);
            OP_STX:  wr_word(ea, idx_r);
            OP_STL:  wr_word(ea, lnk_r);
            OP_ADD:  acc_r = acc_r + w;
            OP_SUB:  acc_r = acc_r - w;
            OP_MUL: begin
                prod = acc_r * w;
                acc_r = prod[23:0];
            end
            OP_DIV: begin
                if (w == 0) begin
                    halt_with(ST_DIV0);
                    return;
                end
                acc_r = acc_r / w;
            end
            OP_COMP: cc_r = (acc_r > w) ? CC_GT : ((acc_r < w) ? CC_LT : CC_EQ);
            OP_TIX, OP_RD, OP_STSW: ;
            OP_JEQ:  if (cc_r & CC_EQ) next_pc = ea;
            OP_JGT:  if (cc_r & CC_GT) next_pc = ea;
            OP_JLT:  if (cc_r & CC_LT) next_pc = ea;
            OP_J:    next_pc = ea;
            OP_AND:  acc_r = acc_r & w;
            OP_OR:   acc_r = acc_r | w;
            OP_JSUB: begin
                lnk_r = next_pc;
                next_pc = ea;
            end
            OP_RSUB: next_pc = lnk_r[15:0];
            OP_LDCH: acc_r[23:16] = rd_byte(ea);
            OP_STCH: mem_img[slot(ea)] = acc_r[23:16];
            OP_WD: begin
                r.dev_write = 1;
                r.dev_id = ea[7:0];
                r.dev_byte = acc_r[23:16];
            end
            OP_TD:   cc_r = cc_r | CC_EQ;
            default: begin
                halt_with(ST_BADOP);
                return;
            end
        endcase
        pc_r = next_pc;
        if (pc_r >= MemDepth) halt_with(ST_PCOOR);
    endfunction

    function automatic t_out_item core_step(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.cmd)
            CMD_WRITE: mem_img[slot(it.address)] = it.byte_in;
            CMD_SETPC: begin
                pc_r = it.address;
                halted_r = 0;
                halt_code_r = ST_RUN;
            end
            CMD_EXEC: if (!halted_r) exec_instr(r);
            default: ;
        endcase
        r.status = halted_r ? halt_code_r : ST_RUN;
        r.pc_now = pc_r;
        r.acc_now = acc_r;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        n_fail++;
    endtask

    task automatic push_item(logic [1:0] cmd, int addr, logic [7:0] b);
        t_in_item it;
        it.cmd = cmd;
        it.address = addr[14:0];
        it.byte_in = b;
        pending_q.push_back(it);
    endtask

    task automatic push_instr(int addr, logic [7:0] op, logic [15:0] field);
        push_item(CMD_WRITE, addr, op);
        push_item(CMD_WRITE, addr + 1, field[15:8]);
        push_item(CMD_WRITE, addr + 2, field[7:0]);
    endtask

    // a short program with its data, then a run over it
    task automatic push_program();
        int base, n_ins, n_data, dbase, a;
        logic [7:0] op;
        logic [23:0] v;
        logic [15:0] field;
        case ($urandom_range(0, 9))
            0:       base = $urandom_range(32760, 32767);
            1:       base = $urandom_range(0, 32767);
            default: base = $urandom_range(0, 255);
        endcase
        dbase = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32767) : $urandom_range(256, 320);
        n_ins = $urandom_range(1, 5);
        n_data = $urandom_range(0, 4);
        for (int i = 0; i < n_data; i++) begin
            a = dbase + 3 * $urandom_range(0, 7);
            v = $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 3)) : 24'($urandom);
            for (int k = 0; k < 3; k++) push_item(CMD_WRITE, a + k, v[23 - 8 * k -: 8]);
        end
        for (int i = 0; i < n_ins; i++) begin
            if ($urandom_range(0, 15) == 0) op = 8'($urandom);
            else op = op_list[$urandom_range(0, 25)] | 8'($urandom_range(0, 3));
            field[15] = $urandom_range(0, 3) == 0;
            field[14:0] = $urandom_range(0, 7) == 0 ? 15'($urandom)
                                                    : 15'(dbase + 3 * $urandom_range(0, 7));
            push_instr(base + 3 * i, op, field);
        end
        if ($urandom_range(0, 7) == 0) push_item(CMD_NOP, $urandom, 8'($urandom));
        push_item(CMD_SETPC, base, 8'($urandom));
        for (int i = 0; i < n_ins + $urandom_range(0, 3); i++)
            push_item(CMD_EXEC, $urandom, 8'($urandom));
    endtask

    // driver: bursts of items with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_q.push_back(core_step(i_data));
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 0;
                end else if (pending_q.size() > 0) begin
                    i_valid <= 1;
                    i_data <= pending_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
                    end
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    int hold_left = 0;
    bit hold_done = 0;
    int mode_left = 0;
    int stall_pct = 0;
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected item", o_data.pc_now, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_data.status !== want.status) report("status", o_data.status, want.status);
                    if (o_data.pc_now !== want.pc_now) report("pc_now", o_data.pc_now, want.pc_now);
                    if (o_data.acc_now !== want.acc_now)
                        report("acc_now", o_data.acc_now, want.acc_now);
                    if (o_data.dev_write !== want.dev_write)
                        report("dev_write", o_data.dev_write, want.dev_write);
                    if (o_data.dev_id !== want.dev_id) report("dev_id", o_data.dev_id, want.dev_id);
                    if (o_data.dev_byte !== want.dev_byte)
                        report("dev_byte", o_data.dev_byte, want.dev_byte);
                end
            end
            if (!hold_done && n_accepted >= 300) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 200);
                stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(10, 80);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1;
            end else begin
                i_stall <= $urandom_range(0, 99) < stall_pct;
            end
        end
    end

    // watchdog on cycles with no handshake; covers the clearing pass after reset
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("FAIL sic_cpu_core_top");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MemDepth; i++) mem_img[i] = 0;
        acc_r = 0;
        idx_r = 0;
        lnk_r = 0;
        cc_r = 0;
        pc_r = 0;
        halted_r = 0;
        halt_code_r = ST_RUN;
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_data = '0;

        // directed: extremes, wrap at top of memory, halts, no-op command
        push_item(CMD_NOP, 15'h7FFF, 8'hFF);
        push_item(CMD_WRITE, 15'h7FFF, 8'hFF);
        push_item(CMD_EXEC, 0, 8'd0);
        push_item(CMD_SETPC, 15'h7FFE, 8'd0);
        push_item(CMD_EXEC, 0, 8'd0);
        push_item(CMD_EXEC, 0, 8'd0);
        push_instr(3, OP_DIV, 16'h0040);
        push_item(CMD_SETPC, 3, 8'd0);
        push_item(CMD_EXEC, 0, 8'd0);
        push_item(CMD_EXEC, 0, 8'd0);
        push_instr(6, 8'hFF, 16'hFFFF);
        push_item(CMD_SETPC, 6, 8'd0);
        push_item(CMD_EXEC, 0, 8'd0);
        push_instr(9, OP_WD, 16'h80AB);
        push_item(CMD_SETPC, 9, 8'd0);
        push_item(CMD_EXEC, 0, 8'd0);
        push_item(CMD_WRITE, 15'h7FFF, 8'h00);

        while (pending_q.size() < NumItems) push_program();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        wait (pending_q.size() == 0 && !i_valid && expected_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_fail == 0 && expected_q.size() == 0) begin
            $display("PASS sic_cpu_core_top");
        end else begin
            $display("FAIL sic_cpu_core_top");
        end
        $finish;
    end

endmodule
